FILE: rtl/core/ipdr_pkg.sv
// Types, constants and helper functions of the planar dead-reckoning core.
`default_nettype none
package ipdr_pkg;

    // Heading step divisor: 16 * 360 * 1e6 (rate LSB, degrees per turn, us per s)
    localparam logic [32:0] HEAD_DIV  = 33'd5760000000;
    localparam logic [31:0] HEAD_HALF = 32'd2880000000;
    // floor(2^64 / HEAD_DIV): estimate lands on the rounded step or one below it
    localparam logic [31:0] HEAD_RECIP = 32'd3202559735;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int CORDIC_ITER = 20;
    localparam int DIV_STEPS   = 5;
    localparam int MUL_STEPS   = 9;

    localparam logic signed [49:0] VEL_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] VEL_MIN = -50'sd140737488355328;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_RATE  = 10'b00_0000_0010,
        S_DINIT = 10'b00_0000_0100,
        S_DIV   = 10'b00_0000_1000,
        S_HEAD  = 10'b00_0001_0000,
        S_CINIT = 10'b00_0010_0000,
        S_CORD  = 10'b00_0100_0000,
        S_CRND  = 10'b00_1000_0000,
        S_MUL   = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } state_t;

    // Arctangent of 2^-i in turns, 2^32 = one turn
    function automatic logic signed [32:0] atan_turn(input logic [4:0] idx);
        logic signed [32:0] v;
        case (idx)
            5'd0:    v = 33'sd536870912;
            5'd1:    v = 33'sd316933406;
            5'd2:    v = 33'sd167458907;
            5'd3:    v = 33'sd85004756;
            5'd4:    v = 33'sd42667331;
            5'd5:    v = 33'sd21354465;
            5'd6:    v = 33'sd10679838;
            5'd7:    v = 33'sd5340245;
            5'd8:    v = 33'sd2670163;
            5'd9:    v = 33'sd1335087;
            5'd10:   v = 33'sd667544;
            5'd11:   v = 33'sd333772;
            5'd12:   v = 33'sd166886;
            5'd13:   v = 33'sd83443;
            5'd14:   v = 33'sd41722;
            5'd15:   v = 33'sd20861;
            5'd16:   v = 33'sd10430;
            5'd17:   v = 33'sd5215;
            5'd18:   v = 33'sd2608;
            5'd19:   v = 33'sd1304;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    // Round a CORDIC coordinate to Q1.15, ties away from zero, clamp to +-32767
    function automatic logic signed [15:0] round_q15(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [19:0] r;
        logic signed [15:0] o;
        t = {v[33], v} + 35'sd16384 - {34'd0, v[33]};
        r = t[34:15];
        if (r > 20'sd32767)
            o = 16'sd32767;
        else if (r < -20'sd32767)
            o = -16'sd32767;
        else
            o = r[15:0];
        return o;
    endfunction

    // velocity + round(p / 2^15), saturated to 48 bits
    function automatic logic signed [47:0] vel_update(input logic signed [47:0] v,
                                                     input logic signed [64:0] p);
        logic signed [49:0] pp;
        logic signed [49:0] rp;
        logic signed [49:0] sum;
        logic signed [47:0] o;
        pp  = p[49:0] + 50'sd16384 - {49'd0, p[64]};
        rp  = pp >>> 15;
        sum = {{2{v[47]}}, v} + rp;
        if (sum > VEL_MAX)
            o = VEL_MAX[47:0];
        else if (sum < VEL_MIN)
            o = VEL_MIN[47:0];
        else
            o = sum[47:0];
        return o;
    endfunction

    // Saturating signed 64-bit add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] o;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            o = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            o = s[63:0];
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/imu_planar_dead_reckoning.sv
// Planar IMU dead reckoning: heading, world velocity and position integrator.
//
//  channel  dir  handshake          payload
//  s_axis   in   s_tvalid/s_tready  s_tdata (sample / pose), s_tuser (cmd)
//  m_axis   out  m_tvalid/m_tready  m_tdata (pose and velocity)
//
// An update word passes idle, one multiply, the divider set-up, five divider steps
// on the shared multiplier for the heading step (reciprocal estimate,
// back-multiply, round up once), the heading update, 20 CORDIC iterations with
// set-up and rounding, nine steps through the shared 48x17 multiplier and the
// finish step; a set-pose word goes from idle straight to the finish step.
// Reset clears the pose, velocity and handshake state. s_tready is high only
// when idle; a finished result waits in the output register for m_tready.
`default_nettype none
module imu_planar_dead_reckoning
    import ipdr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // gyro_rate[15:0], accel_x[31:16], accel_y[47:32], step_time[63:48],
    // new_x[127:64], new_y[191:128], new_heading[207:192]
    input  wire logic [207:0] s_tdata,
    // cmd[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x[63:0], pos_y[127:64], heading[143:128], vel_x[191:144], vel_y[239:192]
    output logic [239:0]      m_tdata
);

    state_t state_reg, state_next;
    logic [4:0] cnt_reg;

    // latched sample
    logic signed [15:0] rate_reg, ax_reg, ay_reg;
    logic [15:0]        dt_reg;

    // navigation state
    logic [31:0]        heading_reg;
    logic signed [47:0] vx_reg, vy_reg;
    logic signed [63:0] px_reg, py_reg;

    // heading step divider
    logic [30:0] mag_reg;
    logic [63:0] dacc_reg;
    logic [31:0] quot_reg;
    logic        neg_reg;

    // CORDIC
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic [1:0]         quad_reg;
    logic signed [15:0] cos_reg, sin_reg;

    // multiply chain
    logic signed [64:0] prod_reg;
    logic signed [32:0] acc_reg, awx_reg, awy_reg;

    // shared multiplier
    logic signed [47:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [16:0] dt_s;

    assign dt_s = {1'b0, dt_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_RATE)
        begin
            mul_a = 48'(rate_reg);
            mul_b = dt_s;
        end
        else if (state_reg == S_DIV)
        begin
            case (cnt_reg)
                5'd0:    begin mul_a = 48'(mag_reg);  mul_b = {1'b0, HEAD_RECIP[15:0]}; end
                5'd1:    begin mul_a = 48'(mag_reg);  mul_b = {1'b0, HEAD_RECIP[31:16]}; end
                5'd2:    begin mul_a = 48'(HEAD_DIV); mul_b = {1'b0, quot_reg[15:0]}; end
                5'd3:    begin mul_a = 48'(HEAD_DIV); mul_b = {1'b0, quot_reg[31:16]}; end
                default: begin mul_a = '0;            mul_b = '0; end
            endcase
        end
        else
        begin
            case (cnt_reg)
                5'd0:    begin mul_a = 48'(ax_reg);  mul_b = 17'(cos_reg); end
                5'd1:    begin mul_a = 48'(ay_reg);  mul_b = 17'(sin_reg); end
                5'd2:    begin mul_a = 48'(ax_reg);  mul_b = 17'(sin_reg); end
                5'd3:    begin mul_a = 48'(ay_reg);  mul_b = 17'(cos_reg); end
                5'd4:    begin mul_a = 48'(awx_reg); mul_b = dt_s; end
                5'd5:    begin mul_a = 48'(awy_reg); mul_b = dt_s; end
                5'd6:    begin mul_a = vx_reg;       mul_b = dt_s; end
                5'd7:    begin mul_a = vy_reg;       mul_b = dt_s; end
                default: begin mul_a = '0;           mul_b = '0; end
            endcase
        end
    end

    assign mul_p = 65'(mul_a) * 65'(mul_b);

    // divider: accumulate split products, then check the remainder once
    logic [63:0] div_sum;
    logic [63:0] div_num;
    logic [63:0] div_rem;
    logic        div_up;
    assign div_sum = dacc_reg + {mul_p[47:0], 16'd0};
    assign div_num = {1'b0, mag_reg, 32'd0} + {32'd0, HEAD_HALF};
    assign div_rem = div_num - dacc_reg;
    assign div_up  = div_rem >= {31'd0, HEAD_DIV};

    // CORDIC quadrant split of the new heading
    logic [31:0] head_off;
    logic [1:0]  quad_w;
    logic [31:0] resid;
    assign head_off = heading_reg + 32'h2000_0000;
    assign quad_w   = head_off[31:30];
    assign resid    = heading_reg - {quad_w, 30'd0};

    logic signed [33:0] cdx, cdy;
    assign cdx = cy_reg >>> cnt_reg;
    assign cdy = cx_reg >>> cnt_reg;

    logic signed [15:0] c_rnd, s_rnd;
    assign c_rnd = round_q15(cx_reg);
    assign s_rnd = round_q15(cy_reg);

    logic [30:0] mag_w;
    assign mag_w = prod_reg[64] ? 31'(-prod_reg) : prod_reg[30:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = s_tuser ? S_FIN : S_RATE;
            S_RATE:  state_next = S_DINIT;
            S_DINIT: state_next = S_DIV;
            S_DIV:   if (cnt_reg == 5'(DIV_STEPS - 1)) state_next = S_HEAD;
            S_HEAD:  state_next = S_CINIT;
            S_CINIT: state_next = S_CORD;
            S_CORD:  if (cnt_reg == 5'(CORDIC_ITER - 1)) state_next = S_CRND;
            S_CRND:  state_next = S_MUL;
            S_MUL:   if (cnt_reg == 5'(MUL_STEPS - 1)) state_next = S_FIN;
            S_FIN:   if (!m_tvalid || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_tvalid    <= 1'b0;
            heading_reg <= '0;
            vx_reg      <= '0;
            vy_reg      <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 5'd1;

            if (state_reg == S_FIN && (!m_tvalid || m_tready))
                m_tvalid <= 1'b1;
            else if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;

            // load pose and clear velocity
            if (state_reg == S_IDLE && s_tvalid && s_tuser)
            begin
                px_reg      <= s_tdata[127:64];
                py_reg      <= s_tdata[191:128];
                heading_reg <= {s_tdata[207:192], 16'd0};
                vx_reg      <= '0;
                vy_reg      <= '0;
            end

            // advance heading by the divided step
            if (state_reg == S_HEAD)
                heading_reg <= neg_reg ? heading_reg - quot_reg : heading_reg + quot_reg;

            // integrate velocity then position
            if (state_reg == S_MUL)
            begin
                case (cnt_reg)
                    5'd5:    vx_reg <= vel_update(vx_reg, prod_reg);
                    5'd6:    vy_reg <= vel_update(vy_reg, prod_reg);
                    5'd7:    px_reg <= sat_add64(px_reg, prod_reg[63:0]);
                    5'd8:    py_reg <= sat_add64(py_reg, prod_reg[63:0]);
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            rate_reg <= s_tdata[15:0];
            ax_reg   <= s_tdata[31:16];
            ay_reg   <= s_tdata[47:32];
            dt_reg   <= s_tdata[63:48];
        end

        if (state_reg == S_RATE || state_reg == S_MUL)
            prod_reg <= mul_p;

        if (state_reg == S_DINIT)
        begin
            mag_reg <= mag_w;
            neg_reg <= prod_reg[64];
        end

        // heading step: reciprocal estimate, back-multiply, round up when short
        if (state_reg == S_DIV)
        begin
            case (cnt_reg)
                5'd0:    dacc_reg <= mul_p[63:0];
                5'd1:    quot_reg <= div_sum[63:32];
                5'd2:    dacc_reg <= mul_p[63:0];
                5'd3:    dacc_reg <= div_sum;
                5'd4:    quot_reg <= quot_reg + {31'd0, div_up};
                default: ;
            endcase
        end

        if (state_reg == S_CINIT)
        begin
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= 33'(signed'(resid));
            quad_reg <= quad_w;
        end
        if (state_reg == S_CORD)
        begin
            if (!cz_reg[32])
            begin
                cx_reg <= cx_reg - cdx;
                cy_reg <= cy_reg + cdy;
                cz_reg <= cz_reg - atan_turn(cnt_reg);
            end
            else
            begin
                cx_reg <= cx_reg + cdx;
                cy_reg <= cy_reg - cdy;
                cz_reg <= cz_reg + atan_turn(cnt_reg);
            end
        end

        // rotate rounded results by the quadrant
        if (state_reg == S_CRND)
        begin
            case (quad_reg)
                2'd0:    begin cos_reg <= c_rnd;  sin_reg <= s_rnd;  end
                2'd1:    begin cos_reg <= -s_rnd; sin_reg <= c_rnd;  end
                2'd2:    begin cos_reg <= -c_rnd; sin_reg <= -s_rnd; end
                default: begin cos_reg <= s_rnd;  sin_reg <= -c_rnd; end
            endcase
        end

        // combine rotated acceleration terms
        if (state_reg == S_MUL)
        begin
            case (cnt_reg)
                5'd1:    acc_reg <= prod_reg[32:0];
                5'd2:    awx_reg <= acc_reg - prod_reg[32:0];
                5'd3:    acc_reg <= prod_reg[32:0];
                5'd4:    awy_reg <= acc_reg + prod_reg[32:0];
                default: ;
            endcase
        end

        // hold the result word
        if (state_reg == S_FIN && (!m_tvalid || m_tready))
            m_tdata <= {vy_reg, vx_reg, heading_reg[31:16], py_reg, px_reg};
    end

    // input is blocked for the cycle after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // CORDIC ends after its last iteration
    a_cordic_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CORD && cnt_reg == 5'(CORDIC_ITER - 1)) |=> (state_reg == S_CRND))
        else $error("CORDIC count overrun");

    // a result appears only from the finish step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside finish");

endmodule
`default_nettype wire
